// ----- sv/hmt_pkg.sv -----
// ----------------------------------------------------------------------------
// hmt_pkg - shared types for the homogeneous matrix transform
// Request codes, the control word that rides the cell chain, and the width
// helpers that the top level and the cells both derive their datapaths from.
// ----------------------------------------------------------------------------
package hmt_pkg;

  // Request kinds, carried in the low two bits of the input tuser
  localparam logic [1:0] REQ_WR_CUR  = 2'd0;
  localparam logic [1:0] REQ_WR_OP   = 2'd1;
  localparam logic [1:0] REQ_COMPOSE = 2'd2;
  localparam logic [1:0] REQ_XFORM   = 2'd3;

  // Width of one coordinate on the stream ports
  localparam int COORD_W = 32;

  // Result queue behind the chain
  localparam int FIFO_DEPTH = 16;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH) + 1;

  // Control word handed from cell to cell; for compose words row holds the
  // operand column being pushed through.
  typedef struct packed {
    logic       valid;
    logic [1:0] kind;
    logic [1:0] row;
  } ctl_t;

  // Vector lanes are wide enough for a raw coordinate and for a matrix element
  function automatic int vec_width(input int elem_width);
    return (elem_width > COORD_W) ? elem_width : COORD_W;
  endfunction

  // Exact sum of four truncated products: element x vector, minus the
  // fraction, plus two bits of growth
  function automatic int acc_width(input int elem_width, input int frac_bits);
    return elem_width + vec_width(elem_width) - frac_bits + 2;
  endfunction

endpackage

// ----- sv/homogeneous_matrix_transform.sv -----
// ----------------------------------------------------------------------------
// homogeneous_matrix_transform - 4x4 fixed-point vertex transform
// Keeps a current and an operand matrix, takes row writes, composes
// current = current * operand and transforms homogeneous vertices.
// ----------------------------------------------------------------------------
// Channel  Dir  Word                                    Accepted when
// s_*      in   tdata {in_w,in_z,in_y,in_x},             s_tvalid & s_tready
//               tuser {row_index,req_type}
// m_*      out  tdata {out_w,out_z,out_y,out_x},         m_tvalid & m_tready
//               tuser {overflow}
//
// Row writes and transforms go in at one word per cycle while s_tready is
// high; a transform's result passes through the chain of four two-stage
// column cells, the saturation step into the result queue and the queue's
// output register.
// A compose holds s_tready low while four operand columns go down the chain
// back to back and each lands in its cell as it comes out.
// Reset (rst, synchronous) loads identity into both matrices and empties
// the queue. The chain never stalls; a 16-word result queue with credit
// counting absorbs m_tready back-pressure, and s_tready drops when no credit is left.
// ----------------------------------------------------------------------------
module homogeneous_matrix_transform
  import hmt_pkg::*;
#(
  parameter int FRAC_BITS  = 16,
  parameter int ELEM_WIDTH = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [4*COORD_W-1:0] s_tdata,   // in_x, in_y, in_z, in_w
  input  logic [3:0]           s_tuser,   // req_type, row_index
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [4*COORD_W-1:0] m_tdata,   // out_x, out_y, out_z, out_w
  output logic                 m_tuser    // overflow
);

  localparam int VecW  = vec_width(ELEM_WIDTH);
  localparam int AccW  = acc_width(ELEM_WIDTH, FRAC_BITS);
  localparam int FifoW = 4*COORD_W + 1;
  localparam logic [ELEM_WIDTH-1:0] One =
    {{(ELEM_WIDTH-1){1'b0}}, 1'b1} << FRAC_BITS;
  localparam logic [ELEM_WIDTH-1:0] ElemMax = {1'b0, {(ELEM_WIDTH-1){1'b1}}};
  localparam logic [ELEM_WIDTH-1:0] ElemMin = {1'b1, {(ELEM_WIDTH-1){1'b0}}};

  typedef enum logic [2:0] {
    ST_RUN   = 3'b001,
    ST_ISSUE = 3'b010,
    ST_DRAIN = 3'b100
  } state_t;

  state_t state, state_next;
  logic [1:0] issue_cnt;

  // Operand matrix, one register per column so a compose reads a column at once
  logic [4*ELEM_WIDTH-1:0] op_col [4];

  logic                    compose_overflow;
  logic                    cmp_ovf_acc;

  // Input decode
  logic [1:0]        req;
  logic [1:0]        row;
  logic              s_accept;
  logic [4*VecW-1:0] in_vec;
  logic [4*VecW-1:0] col_vec;

  // Cell chain
  ctl_t              chain_ctl [5];
  logic [4*VecW-1:0] chain_vec [5];
  logic [4*AccW-1:0] chain_acc [5];

  // Exit stage
  ctl_t                    exit_ctl;
  logic                    exit_xform;
  logic                    exit_compose;
  logic [ELEM_WIDTH-1:0]   sat_val [4];
  logic [3:0]              sat_flag;
  logic [4*ELEM_WIDTH-1:0] load_col;
  logic [3:0]              load_en;
  logic [FifoW-1:0]        fifo_din;

  // Result queue
  logic [FifoW-1:0]      fifo_mem [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr;
  logic [FIFO_PTR_W-1:0] rd_ptr;
  logic [FIFO_PTR_W-1:0] fifo_count;
  logic [FIFO_PTR_W-1:0] inflight;
  logic                  fifo_push;
  logic                  fifo_pop;
  logic                  fifo_load;
  logic [FifoW-1:0]      out_word;

  assign req      = s_tuser[1:0];
  assign row      = s_tuser[3:2];
  assign s_accept = s_tvalid && s_tready;

  // Take words only in normal run and while the queue has a credit left
  assign s_tready = (state == ST_RUN) && (inflight != FIFO_PTR_W'(FIFO_DEPTH));

  // Widen raw coordinates and the selected operand column to the lane width
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      in_vec[k*VecW +: VecW]  = VecW'($signed(s_tdata[k*COORD_W +: COORD_W]));
      col_vec[k*VecW +: VecW] = VecW'($signed(op_col[issue_cnt][k*ELEM_WIDTH +: ELEM_WIDTH]));
    end
  end

  // Chain entry: compose columns while issuing, else current-matrix row writes and transforms
  always_comb begin
    chain_ctl[0] = '0;
    chain_vec[0] = in_vec;
    chain_acc[0] = '0;
    if (state == ST_ISSUE) begin
      chain_ctl[0] = '{valid: 1'b1, kind: REQ_COMPOSE, row: issue_cnt};
      chain_vec[0] = col_vec;
    end else if (s_accept && (req == REQ_WR_CUR || req == REQ_XFORM)) begin
      chain_ctl[0] = '{valid: 1'b1, kind: req, row: row};
    end
  end

  for (genvar c = 0; c < 4; c++) begin : g_cell
    hmt_cell #(
      .ELEM_WIDTH (ELEM_WIDTH),
      .FRAC_BITS  (FRAC_BITS),
      .COL        (c)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .in_ctl   (chain_ctl[c]),
      .in_vec   (chain_vec[c]),
      .in_acc   (chain_acc[c]),
      .load_en  (load_en[c]),
      .load_col (load_col),
      .out_ctl  (chain_ctl[c+1]),
      .out_vec  (chain_vec[c+1]),
      .out_acc  (chain_acc[c+1])
    );
  end

  // Saturate the four exact sums to the element width
  always_comb begin
    exit_ctl     = chain_ctl[4];
    exit_xform   = exit_ctl.valid && exit_ctl.kind == REQ_XFORM;
    exit_compose = exit_ctl.valid && exit_ctl.kind == REQ_COMPOSE;
    for (int i = 0; i < 4; i++) begin
      if ((&chain_acc[4][i*AccW+ELEM_WIDTH-1 +: AccW-ELEM_WIDTH+1]) ||
          !(|chain_acc[4][i*AccW+ELEM_WIDTH-1 +: AccW-ELEM_WIDTH+1])) begin
        sat_val[i]  = chain_acc[4][i*AccW +: ELEM_WIDTH];
        sat_flag[i] = 1'b0;
      end else begin
        sat_val[i]  = chain_acc[4][i*AccW+AccW-1] ? ElemMin : ElemMax;
        sat_flag[i] = 1'b1;
      end
      load_col[i*ELEM_WIDTH +: ELEM_WIDTH] = sat_val[i];
      // Extend or trim to the 32-bit coordinate on the port
      fifo_din[i*COORD_W +: COORD_W] = COORD_W'($signed(sat_val[i]));
      load_en[i] = exit_compose && exit_ctl.row == 2'(i);
    end
    fifo_din[FifoW-1] = (|sat_flag) || compose_overflow;
  end

  // Compose sequencer
  always_comb begin
    state_next = state;
    case (state)
      ST_RUN: begin
        if (s_accept && req == REQ_COMPOSE) state_next = ST_ISSUE;
      end
      ST_ISSUE: begin
        if (issue_cnt == 2'd3) state_next = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (exit_compose && exit_ctl.row == 2'd3) state_next = ST_RUN;
      end
      default: state_next = ST_RUN;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= ST_RUN;
      issue_cnt        <= '0;
      compose_overflow <= 1'b0;
      cmp_ovf_acc      <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_ISSUE) begin
        issue_cnt <= issue_cnt + 2'd1;
      end else begin
        issue_cnt <= '0;
      end
      // Gather saturation over the four columns, publish on the last one
      if (exit_compose) begin
        if (exit_ctl.row == 2'd0) begin
          cmp_ovf_acc <= |sat_flag;
        end else begin
          cmp_ovf_acc <= cmp_ovf_acc || (|sat_flag);
        end
        if (exit_ctl.row == 2'd3) begin
          compose_overflow <= cmp_ovf_acc || (|sat_flag);
        end
      end
    end
  end

  // Operand rows are written straight away; only compose reads them
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < 4; k++) begin
        op_col[k] <= {{(3*ELEM_WIDTH){1'b0}}, One} << (k*ELEM_WIDTH);
      end
    end else if (s_accept && req == REQ_WR_OP) begin
      for (int k = 0; k < 4; k++) begin
        op_col[k][row*ELEM_WIDTH +: ELEM_WIDTH] <= in_vec[k*VecW +: ELEM_WIDTH];
      end
    end
  end

  // Result queue and credits; the head word moves into the output register
  // whenever that register is empty or being taken
  assign fifo_push  = exit_xform;
  assign fifo_pop   = m_tvalid && m_tready;
  assign fifo_count = wr_ptr - rd_ptr;
  assign fifo_load  = (wr_ptr != rd_ptr) && (!m_tvalid || m_tready);
  assign m_tdata    = out_word[4*COORD_W-1:0];
  assign m_tuser    = out_word[FifoW-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr   <= '0;
      rd_ptr   <= '0;
      inflight <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (fifo_push) wr_ptr <= wr_ptr + FIFO_PTR_W'(1);
      if (fifo_load) rd_ptr <= rd_ptr + FIFO_PTR_W'(1);
      if (fifo_load) begin
        m_tvalid <= 1'b1;
      end else if (fifo_pop) begin
        m_tvalid <= 1'b0;
      end
      // Hold a credit from accept of a transform until its word is taken
      if ((s_accept && req == REQ_XFORM) && !fifo_pop) begin
        inflight <= inflight + FIFO_PTR_W'(1);
      end else if (!(s_accept && req == REQ_XFORM) && fifo_pop) begin
        inflight <= inflight - FIFO_PTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fifo_push) fifo_mem[wr_ptr[FIFO_PTR_W-2:0]] <= fifo_din;
    if (fifo_load) out_word <= fifo_mem[rd_ptr[FIFO_PTR_W-2:0]];
  end

`ifndef ASSERT_OFF
  a_no_fifo_overrun: assert property (@(posedge clk) disable iff (rst)
    fifo_push |-> (fifo_count != FIFO_PTR_W'(FIFO_DEPTH)))
    else $error("result queue overrun");

  a_credit_covers_queue: assert property (@(posedge clk) disable iff (rst)
    fifo_count <= inflight)
    else $error("queue holds more words than credits issued");

  a_no_accept_in_compose: assert property (@(posedge clk) disable iff (rst)
    (state != ST_RUN) |-> !s_tready)
    else $error("input ready during compose");

  a_compose_exit_in_drain: assert property (@(posedge clk) disable iff (rst)
    exit_compose |-> (state == ST_DRAIN))
    else $error("compose column left the chain outside drain");
`endif

endmodule

// ----- sv/hmt_cell.sv -----
// ----------------------------------------------------------------------------
// hmt_cell - one column cell of the transform chain
// Holds column COL of the current matrix, adds its term of the four dot
// products to the partial sums and hands word, vector and sums to the next
// cell. Two register stages: split multiply, then recombine and accumulate.
// ----------------------------------------------------------------------------
module hmt_cell
  import hmt_pkg::*;
#(
  parameter int ELEM_WIDTH = 32,
  parameter int FRAC_BITS  = 16,
  parameter int COL        = 0,
  localparam int VecW      = vec_width(ELEM_WIDTH),
  localparam int AccW      = acc_width(ELEM_WIDTH, FRAC_BITS)
) (
  input  logic                    clk,
  input  logic                    rst,
  input  ctl_t                    in_ctl,
  input  logic [4*VecW-1:0]       in_vec,
  input  logic [4*AccW-1:0]       in_acc,
  input  logic                    load_en,
  input  logic [4*ELEM_WIDTH-1:0] load_col,
  output ctl_t                    out_ctl,
  output logic [4*VecW-1:0]       out_vec,
  output logic [4*AccW-1:0]       out_acc
);

  localparam int HalfW   = VecW / 2;
  localparam int HiW     = VecW - HalfW;
  localparam int LoMulW  = ELEM_WIDTH + HalfW + 1;
  localparam int HiMulW  = ELEM_WIDTH + HiW;
  localparam int ProdW   = ELEM_WIDTH + VecW;
  localparam int ShW     = ProdW - FRAC_BITS;
  localparam logic signed [ELEM_WIDTH-1:0] One =
    {{(ELEM_WIDTH-1){1'b0}}, 1'b1} << FRAC_BITS;

  logic signed [ELEM_WIDTH-1:0] elem [4];

  logic [VecW-1:0]          v_k;
  logic signed [HalfW:0]    v_lo;
  logic signed [HiW-1:0]    v_hi;
  logic signed [LoMulW-1:0] lo_mul [4];
  logic signed [HiMulW-1:0] hi_mul [4];

  ctl_t                     s1_ctl;
  logic [4*VecW-1:0]        s1_vec;
  logic [4*AccW-1:0]        s1_acc;
  logic signed [LoMulW-1:0] s1_lo [4];
  logic signed [HiMulW-1:0] s1_hi [4];

  logic signed [ProdW-1:0]  prod [4];
  logic signed [ShW-1:0]    shv [4];
  logic [4*AccW-1:0]        acc_next;

  // Split the vector lane: unsigned low half, signed high half
  always_comb begin
    v_k  = in_vec[COL*VecW +: VecW];
    v_lo = $signed({1'b0, v_k[HalfW-1:0]});
    v_hi = $signed(v_k[VecW-1:HalfW]);
    for (int i = 0; i < 4; i++) begin
      lo_mul[i] = elem[i] * v_lo;
      hi_mul[i] = elem[i] * v_hi;
    end
  end

  // Recombine, drop the fraction, add to the running sum
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      prod[i] = (ProdW'(s1_hi[i]) <<< HalfW) + ProdW'(s1_lo[i]);
      shv[i]  = ShW'(prod[i] >>> FRAC_BITS);
      acc_next[i*AccW +: AccW] = $signed(s1_acc[i*AccW +: AccW]) + AccW'(shv[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_ctl  <= '0;
      out_ctl <= '0;
      for (int i = 0; i < 4; i++) begin
        elem[i] <= (i == COL) ? One : '0;
      end
    end else begin
      s1_ctl  <= in_ctl;
      out_ctl <= s1_ctl;
      // A row write updates this cell's element as the word passes, so older
      // transforms ahead of it and newer ones behind it each see their matrix
      if (in_ctl.valid && in_ctl.kind == REQ_WR_CUR) begin
        elem[in_ctl.row] <= v_k[ELEM_WIDTH-1:0];
      end else if (load_en) begin
        for (int i = 0; i < 4; i++) begin
          elem[i] <= load_col[i*ELEM_WIDTH +: ELEM_WIDTH];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    s1_vec  <= in_vec;
    s1_acc  <= in_acc;
    s1_lo   <= lo_mul;
    s1_hi   <= hi_mul;
    out_vec <= s1_vec;
    out_acc <= acc_next;
  end

endmodule
